/* hdl/hfcd_pkg.sv */
// ----------------------------------------------------------------------------
// hfcd_pkg
// Shared types, constants and codes of the header field covert deframer.
// ----------------------------------------------------------------------------
package hfcd_pkg;

    // transfer framing
    localparam int unsigned NAME_BYTES    = 16;
    localparam int unsigned CALIB_PACKETS = 10;
    localparam logic [7:0]  UDP_PROTOCOL  = 8'd17;

    // register reset values
    localparam logic        MODE_RESET         = 1'b0;
    localparam logic [15:0] COVERT_PORT_RESET  = 16'd9091;
    localparam logic [15:0] SNIFF_PORT_RESET   = 16'd9090;
    localparam logic [31:0] HOST_ADDRESS_RESET = 32'hC0A8_010B;

    // register indexes on the configuration channel
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COVERT_PORT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SNIFF_PORT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOST_ADDRESS = 3'd3;

    // mode codes
    localparam logic MODE_TOS = 1'b0;
    localparam logic MODE_TTL = 1'b1;

    // section codes of a result
    localparam logic [1:0] SEC_NAME = 2'd0;
    localparam logic [1:0] SEC_SIZE = 2'd1;
    localparam logic [1:0] SEC_DATA = 2'd2;

    // calibration counter and sum widths
    localparam int unsigned CALIB_CNT_W = 4;
    localparam int unsigned TTL_SUM_W   = 12;

    // average = (sum * CALIB_RECIP) >> RECIP_SHIFT, exact for every 12-bit sum
    localparam int unsigned RECIP_SHIFT = 24;
    localparam int unsigned RECIP_W     = 25;
    localparam int unsigned CALIB_RECIP =
        ((2 ** RECIP_SHIFT) + CALIB_PACKETS - 1) / CALIB_PACKETS;
    localparam int unsigned PROD_W      = TTL_SUM_W + RECIP_W;

    // payload widths on the stream ports
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 64;
    localparam int unsigned M_TUSER_W = 2;

    // transfer phase
    typedef enum logic [3:0] {
        PH_NAME = 4'b0001,
        PH_SIZE = 4'b0010,
        PH_DATA = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    // one packet header
    typedef struct packed {
        logic [7:0]  time_to_live;
        logic [7:0]  service_type;
        logic [7:0]  protocol_number;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
    } header_t;

    // configuration registers as seen by the decoder
    typedef struct packed {
        logic        mode;
        logic [15:0] covert_port;
        logic [15:0] sniff_port;
        logic [31:0] host_address;
    } cfg_t;

    // one decoded result with its valid flag
    typedef struct packed {
        logic        valid;
        logic [1:0]  section;
        logic [31:0] value;
        logic [31:0] byte_index;
        logic        transfer_done;
    } result_t;

endpackage

/* hdl/hfcd_decoder.sv */
// ----------------------------------------------------------------------------
// hfcd_decoder
// Holds the transfer and calibration state and decodes one header per step.
// ----------------------------------------------------------------------------
module hfcd_decoder (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  hfcd_pkg::cfg_t    cfg,
    input  hfcd_pkg::header_t hdr,
    output hfcd_pkg::result_t res
);
    import hfcd_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [31:0]            sc_reg, sc_next;
    logic [5:0]             bp_reg, bp_next;
    logic [31:0]            buf_reg, buf_next;
    logic [31:0]            fl_reg, fl_next;
    logic [CALIB_CNT_W-1:0] seen_reg, seen_next;
    logic [TTL_SUM_W-1:0]   sum_reg, sum_next;
    logic [7:0]             avg_reg, avg_next;
    logic                   cal_reg, cal_next;

    logic                   match;
    logic                   take;
    logic                   finish;
    logic [7:0]             byte_val;
    logic [31:0]            size_val;
    logic [31:0]            sc_inc;
    logic [31:0]            buf_set;
    logic [5:0]             bp_inc;
    logic [PROD_W-1:0]      avg_prod;

    // average by reciprocal multiplication
    assign avg_prod = PROD_W'(sum_reg) * PROD_W'(CALIB_RECIP);

    assign sc_inc  = sc_reg + 32'd1;
    assign bp_inc  = bp_reg + 6'd1;
    assign buf_set = buf_reg
                   | (32'(hdr.time_to_live > avg_reg) << bp_reg[4:0]);

    // packet filter
    assign match = (phase_reg != PH_DONE)
                && (hdr.protocol_number == UDP_PROTOCOL)
                && (hdr.dest_address == cfg.host_address)
                && ((hdr.dest_port == cfg.covert_port)
                    || (hdr.dest_port == cfg.sniff_port));

    // next state and result
    always_comb begin
        phase_next = phase_reg;
        sc_next    = sc_reg;
        bp_next    = bp_reg;
        buf_next   = buf_reg;
        fl_next    = fl_reg;
        seen_next  = seen_reg;
        sum_next   = sum_reg;
        avg_next   = avg_reg;
        cal_next   = cal_reg;
        take       = 1'b0;
        finish     = 1'b0;
        byte_val   = hdr.service_type;
        size_val   = fl_reg;
        res        = '0;

        // gather a byte, a size or a calibration sample
        if (match) begin
            if (cfg.mode == MODE_TOS) begin
                if (hdr.dest_port == cfg.covert_port) begin
                    if (phase_reg == PH_SIZE) begin
                        size_val = fl_reg
                                 | ({24'd0, hdr.service_type} << {sc_reg[1:0], 3'b000});
                        fl_next  = size_val;
                        sc_next  = sc_inc;
                        finish   = (sc_inc >= 32'd4);
                    end else begin
                        take = 1'b1;
                    end
                end
            end else if (hdr.dest_port == cfg.sniff_port) begin
                if (32'(seen_reg) < CALIB_PACKETS) begin
                    seen_next = seen_reg + CALIB_CNT_W'(1);
                    sum_next  = sum_reg + TTL_SUM_W'(hdr.time_to_live);
                end else if (!cal_reg) begin
                    avg_next = avg_prod[RECIP_SHIFT +: 8];
                    cal_next = 1'b1;
                    buf_next = '0;
                end
            end else if (cal_reg) begin
                buf_next = buf_set;
                bp_next  = bp_inc;
                if (phase_reg == PH_SIZE) begin
                    if (bp_inc >= 6'd32) begin
                        size_val = buf_set;
                        fl_next  = buf_set;
                        finish   = 1'b1;
                    end
                end else if (bp_inc >= 6'd8) begin
                    byte_val = buf_set[7:0];
                    buf_next = '0;
                    bp_next  = '0;
                    take     = 1'b1;
                end
            end
        end

        // a name or data byte is complete
        if (take) begin
            res.valid      = 1'b1;
            res.value      = {24'd0, byte_val};
            res.byte_index = sc_reg;
            sc_next        = sc_inc;
            if (phase_reg == PH_NAME) begin
                res.section = SEC_NAME;
                if (sc_inc == 32'(NAME_BYTES)) begin
                    phase_next = PH_SIZE;
                    sc_next    = '0;
                    bp_next    = '0;
                    buf_next   = '0;
                end
            end else begin
                res.section = SEC_DATA;
                if (sc_inc == fl_reg) begin
                    res.transfer_done = 1'b1;
                    phase_next        = PH_DONE;
                    sc_next           = '0;
                    bp_next           = '0;
                    buf_next          = '0;
                end
            end
        end

        // the size is complete; a zero size ends the transfer
        if (finish) begin
            res.valid   = 1'b1;
            res.section = SEC_SIZE;
            sc_next     = '0;
            bp_next     = '0;
            buf_next    = '0;
            if (size_val == 32'd0) begin
                phase_next        = PH_DONE;
                res.transfer_done = 1'b1;
            end else begin
                phase_next = PH_DATA;
                res.value  = size_val;
            end
        end

        // nothing moves without a step
        if (!step) begin
            res.valid = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_NAME;
            sc_reg    <= '0;
            bp_reg    <= '0;
            buf_reg   <= '0;
            fl_reg    <= '0;
            seen_reg  <= '0;
            sum_reg   <= '0;
            avg_reg   <= '0;
            cal_reg   <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            sc_reg    <= sc_next;
            bp_reg    <= bp_next;
            buf_reg   <= buf_next;
            fl_reg    <= fl_next;
            seen_reg  <= seen_next;
            sum_reg   <= sum_next;
            avg_reg   <= avg_next;
            cal_reg   <= cal_next;
        end
    end

endmodule

/* hdl/header_field_covert_deframer_core.sv */
// ----------------------------------------------------------------------------
// Path: a header accepted into the input register is decoded, and its result
// word is captured in the result register when that register can take it.
// Throughput: one header per cycle; a stalled result word holds the input register.
// Reset: synchronous, active low; clears the valid flags and decoder state and loads register defaults.
// ----------------------------------------------------------------------------
// header_field_covert_deframer_core
// Filters packet headers and recovers a hidden name, size and data stream.
// ----------------------------------------------------------------------------
module header_field_covert_deframer_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // dest_port, dest_address, protocol_number, service_type, time_to_live
    input  logic [hfcd_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // value, byte_index
    output logic [hfcd_pkg::M_TDATA_W-1:0]       m_tdata,
    // section
    output logic [hfcd_pkg::M_TUSER_W-1:0]       m_tuser,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hfcd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                          cfg_data
);
    import hfcd_pkg::*;

    cfg_t        cfg_reg;
    header_t     hdr_reg;
    logic        hdr_valid_reg;
    logic        advance;
    result_t     res;
    logic        out_valid_reg;
    logic [1:0]  out_section_reg;
    logic [31:0] out_value_reg;
    logic [31:0] out_index_reg;
    logic        out_done_reg;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode         <= MODE_RESET;
            cfg_reg.covert_port  <= COVERT_PORT_RESET;
            cfg_reg.sniff_port   <= SNIFF_PORT_RESET;
            cfg_reg.host_address <= HOST_ADDRESS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MODE:         cfg_reg.mode         <= cfg_data[0];
                CFG_COVERT_PORT:  cfg_reg.covert_port  <= cfg_data[15:0];
                CFG_SNIFF_PORT:   cfg_reg.sniff_port   <= cfg_data[15:0];
                CFG_HOST_ADDRESS: cfg_reg.host_address <= cfg_data;
                default:          ;
            endcase
        end
    end

    // input register moves on when the result register can take its word
    assign advance  = hdr_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !hdr_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_valid_reg <= 1'b0;
        end else if (s_tready) begin
            hdr_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            hdr_reg <= header_t'(s_tdata);
        end
    end

    // header decode and transfer state
    hfcd_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .cfg     (cfg_reg),
        .hdr     (hdr_reg),
        .res     (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_section_reg <= res.section;
            out_value_reg   <= res.value;
            out_index_reg   <= res.byte_index;
            out_done_reg    <= res.transfer_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_index_reg, out_value_reg};
    assign m_tuser  = out_section_reg;
    assign m_tlast  = out_done_reg;

endmodule

/* hdl/hfcd_checker.sv */
// ----------------------------------------------------------------------------
// hfcd_checker
// Port-level checks on the result stream of the covert deframer.
// ----------------------------------------------------------------------------
module hfcd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic [hfcd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [hfcd_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                           m_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready
);
    import hfcd_pkg::*;

    // a stalled result word holds still
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("result word changed while stalled");

    // only the three section codes appear
    a_section: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == SEC_NAME || m_tuser == SEC_SIZE || m_tuser == SEC_DATA))
        else $error("unknown section code");

    // a name byte never ends the transfer
    a_name_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == SEC_NAME) |-> !m_tlast)
        else $error("name byte marked last");

    // the size word carries index zero, and a zero size is last
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == SEC_SIZE) |->
            (m_tdata[63:32] == 32'd0) && ((m_tdata[31:0] == 32'd0) == m_tlast))
        else $error("malformed size word");

    // nothing follows the last word of a transfer
    a_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result after end of transfer");

endmodule

bind header_field_covert_deframer_core hfcd_checker u_hfcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the header field covert deframer. Packet headers
// are sent on the input stream. A bench-side decoder of the hidden transfer
// predicts every result word, and the checker compares each received word
// with it field by field. The run covers filtering, calibration, both decode
// modes, back-pressure and the end of the transfer.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hfcd_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned SEGMENT_DATA  = 180;
    localparam int unsigned LIMIT_CYCLES  = 400000;

    // one expected result word
    typedef struct packed {
        logic [1:0]  section;
        logic [31:0] value;
        logic [31:0] byte_index;
        logic        done;
    } decoded_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data = '0;

    header_field_covert_deframer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // bench copy of the registers and of the decoder state
    cfg_t        filter_cfg = {MODE_RESET, COVERT_PORT_RESET, SNIFF_PORT_RESET,
                               HOST_ADDRESS_RESET};
    phase_t      xfer_phase = PH_NAME;
    logic [31:0] section_count = '0;
    logic [5:0]  bit_pos = '0;
    logic [31:0] bit_buf = '0;
    logic [31:0] file_len = '0;
    logic [3:0]  calib_seen = '0;
    logic [11:0] ttl_sum = '0;
    logic [7:0]  ttl_avg = '0;
    logic        calibrated = 1'b0;

    decoded_t    expected_decodes[$];
    logic [31:0] size_target = 32'd500;
    int          error_count = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    logic        hold_rx = 1'b0;
    int unsigned cycle_count = 0;

    // ------------------------------------------------------------------------
    // decoder prediction
    // ------------------------------------------------------------------------
    task automatic expect_word(input logic [1:0] sec, input logic [31:0] val,
                               input logic [31:0] idx, input logic done);
        decoded_t w;
        w.section    = sec;
        w.value      = val;
        w.byte_index = idx;
        w.done       = done;
        expected_decodes = {expected_decodes, w};
    endtask

    task automatic next_phase();
        case (xfer_phase)
            PH_NAME: xfer_phase = PH_SIZE;
            PH_SIZE: xfer_phase = PH_DATA;
            default: xfer_phase = PH_DONE;
        endcase
        section_count = '0;
        bit_pos       = '0;
        bit_buf       = '0;
    endtask

    // size complete: a zero size ends the transfer at once
    task automatic close_size();
        next_phase();
        if (file_len == 32'd0) begin
            xfer_phase = PH_DONE;
            expect_word(SEC_SIZE, 32'd0, 32'd0, 1'b1);
        end else begin
            expect_word(SEC_SIZE, file_len, 32'd0, 1'b0);
        end
    endtask

    // a complete name or data byte
    task automatic accept_byte(input logic [7:0] data_byte);
        logic [31:0] idx;
        idx = section_count;
        section_count = section_count + 32'd1;
        if (xfer_phase == PH_NAME) begin
            expect_word(SEC_NAME, 32'(data_byte), idx, 1'b0);
            if (section_count == NAME_BYTES)
                next_phase();
        end else if (section_count == file_len) begin
            expect_word(SEC_DATA, 32'(data_byte), idx, 1'b1);
            next_phase();
        end else begin
            expect_word(SEC_DATA, 32'(data_byte), idx, 1'b0);
        end
    endtask

    task automatic decode_header(input header_t h);
        if (xfer_phase == PH_DONE)
            return;
        if (h.protocol_number != UDP_PROTOCOL || h.dest_address != filter_cfg.host_address)
            return;
        if (h.dest_port != filter_cfg.covert_port && h.dest_port != filter_cfg.sniff_port)
            return;

        // byte per packet from the service type
        if (filter_cfg.mode == MODE_TOS) begin
            if (h.dest_port != filter_cfg.covert_port)
                return;
            if (xfer_phase == PH_SIZE) begin
                file_len = file_len | (32'(h.service_type) << (8 * section_count[1:0]));
                section_count = section_count + 32'd1;
                if (section_count >= 32'd4)
                    close_size();
            end else begin
                accept_byte(h.service_type);
            end
            return;
        end

        // sniff port wins when both ports match
        if (h.dest_port == filter_cfg.sniff_port) begin
            if (calib_seen < CALIB_PACKETS) begin
                calib_seen = calib_seen + 4'd1;
                ttl_sum    = ttl_sum + 12'(h.time_to_live);
            end else if (!calibrated) begin
                ttl_avg    = 8'(ttl_sum / CALIB_PACKETS);
                calibrated = 1'b1;
                bit_buf    = '0;
            end
            return;
        end
        if (!calibrated)
            return;

        // one bit per packet, least significant first
        bit_buf = bit_buf | (32'(h.time_to_live > ttl_avg) << bit_pos[4:0]);
        bit_pos = bit_pos + 6'd1;
        if (xfer_phase == PH_SIZE) begin
            if (bit_pos >= 6'd32) begin
                file_len = bit_buf;
                close_size();
            end
        end else if (bit_pos >= 6'd8) begin
            logic [7:0] data_byte;
            data_byte = bit_buf[7:0];
            bit_buf   = '0;
            bit_pos   = '0;
            accept_byte(data_byte);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    // well-formed covert packet; during the size phase it encodes size_target
    function automatic header_t covert_header();
        header_t h;
        h.dest_port       = filter_cfg.covert_port;
        h.dest_address    = filter_cfg.host_address;
        h.protocol_number = UDP_PROTOCOL;
        h.service_type    = 8'($urandom);
        h.time_to_live    = 8'($urandom);
        if (xfer_phase == PH_SIZE) begin
            if (filter_cfg.mode == MODE_TOS)
                h.service_type = 8'(size_target >> (8 * section_count[1:0]));
            else if (size_target[bit_pos[4:0]])
                h.time_to_live = 8'($urandom_range(255, int'(ttl_avg) + 1));
            else
                h.time_to_live = 8'($urandom_range(int'(ttl_avg), 0));
        end
        return h;
    endfunction

    // mostly covert packets, some sniff traffic, near misses and noise
    function automatic header_t random_header(output bit carries_data);
        header_t     h;
        int unsigned pick;
        h = covert_header();
        pick = $urandom_range(0, 99);
        carries_data = 1'b0;
        if (pick < 72) begin
            carries_data = 1'b1;
        end else if (pick < 80) begin
            h.dest_port = filter_cfg.sniff_port;
        end else if (pick < 90) begin
            case ($urandom_range(0, 2))
                0: h.protocol_number = h.protocol_number ^ 8'($urandom_range(1, 255));
                1: h.dest_address = h.dest_address ^ (32'd1 << $urandom_range(0, 31));
                default: h.dest_port = h.dest_port ^ 16'($urandom_range(1, 65535));
            endcase
        end else begin
            h.dest_port       = 16'($urandom);
            h.dest_address    = $urandom;
            h.protocol_number = 8'($urandom);
            h.service_type    = 8'($urandom);
            h.time_to_live    = 8'($urandom);
        end
        return h;
    endfunction

    // one header word on the input stream, with an optional gap before it
    task automatic send_header(input header_t h);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tdata  <= h;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        decode_header(h);
    endtask

    // stop sending and wait for every expected word, then settle
    task automatic drain(input int unsigned settle);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_decodes.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:        filter_cfg.mode         = data[0];
            CFG_COVERT_PORT: filter_cfg.covert_port  = data[15:0];
            CFG_SNIFF_PORT:  filter_cfg.sniff_port   = data[15:0];
            CFG_HOST_ADDRESS: filter_cfg.host_address = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // all four registers, with distinct ports; upper bits carry junk
    task automatic program_filter(input logic m, input logic [31:0] host,
                                  input logic [15:0] port);
        write_register(CFG_MODE, {31'($urandom), m});
        write_register(CFG_COVERT_PORT, {16'($urandom), port});
        write_register(CFG_SNIFF_PORT,
                       {16'($urandom), port ^ 16'($urandom_range(1, 65535))});
        write_register(CFG_HOST_ADDRESS, host);
    endtask

    task automatic run_segment(input logic m, input int idle_pct, input int stall_pct,
                               input int unsigned data_items);
        header_t     h;
        bit          is_data;
        int unsigned carried;
        drain(SETTLE_CYCLES);
        program_filter(m, $urandom, 16'($urandom));
        src_idle_pct = idle_pct;
        sink_stall_pct <= stall_pct;
        carried = 0;
        while (carried < data_items) begin
            h = random_header(is_data);
            send_header(h);
            if (is_data)
                carried++;
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // default registers: rejected headers, then name bytes at the extremes
    task automatic test_filtering();
        header_t h;
        h = covert_header();
        h.protocol_number = UDP_PROTOCOL + 8'd1;
        send_header(h);
        h = covert_header();
        h.dest_address = h.dest_address ^ 32'd1;
        send_header(h);
        h = covert_header();
        h.dest_port = filter_cfg.covert_port + 16'd2;
        send_header(h);
        // sniff traffic means nothing in tos mode
        h = covert_header();
        h.dest_port = filter_cfg.sniff_port;
        send_header(h);
        h = covert_header();
        h.service_type = 8'h00;
        h.time_to_live = 8'hFF;
        send_header(h);
        h = covert_header();
        h.service_type = 8'hFF;
        h.time_to_live = 8'h00;
        send_header(h);
    endtask

    // switch to ttl mode mid name, bits before calibration, then calibrate
    task automatic test_calibration();
        header_t h;
        drain(SETTLE_CYCLES);
        write_register(CFG_MODE, {31'd0, MODE_TTL});
        h = covert_header();
        h.time_to_live = 8'hFF;
        send_header(h);
        for (int i = 0; i < CALIB_PACKETS + 2; i++) begin
            h = covert_header();
            h.dest_port = filter_cfg.sniff_port;
            if (i == 0)
                h.time_to_live = 8'hFF;
            else if (i == 1)
                h.time_to_live = 8'h00;
            send_header(h);
        end
    endtask

    // equal ports in both modes, and register extremes
    task automatic test_port_extremes();
        drain(SETTLE_CYCLES);
        write_register(CFG_COVERT_PORT, 32'h0000_FFFF);
        write_register(CFG_SNIFF_PORT, 32'hFFFF_FFFF);
        write_register(CFG_HOST_ADDRESS, 32'hFFFF_FFFF);
        send_header(covert_header());
        drain(SETTLE_CYCLES);
        write_register(CFG_MODE, {31'h7FFF_FFFF, MODE_TOS});
        send_header(covert_header());
        drain(SETTLE_CYCLES);
        write_register(CFG_COVERT_PORT, 32'hFFFF_0000);
        write_register(CFG_SNIFF_PORT, 32'h0000_0000);
        write_register(CFG_HOST_ADDRESS, 32'h0000_0000);
        send_header(covert_header());
    endtask

    // name, size and data across both modes and all idling patterns
    task automatic test_random_traffic();
        logic m;
        m = 1'($urandom_range(0, 1));
        size_target = $urandom_range(450, 510);
        run_segment(m, 0, 0, SEGMENT_DATA);
        run_segment(!m, 64, 0, SEGMENT_DATA);
        run_segment(m, 0, 64, SEGMENT_DATA);
        run_segment(!m, 38, 38, SEGMENT_DATA);
    endtask

    // long receiver hold-off fills the block, then a full drain mid stream
    task automatic test_backpressure();
        drain(SETTLE_CYCLES);
        program_filter(MODE_TOS, $urandom, 16'($urandom));
        src_idle_pct = 0;
        sink_stall_pct <= 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_rx <= 1'b0;
            end
        join_none
        repeat (24) send_header(covert_header());
        drain(0);
        repeat (16) send_header(covert_header());
    endtask

    // run to the end of the transfer, then show that later headers are dropped
    task automatic test_completion();
        header_t     h;
        bit          is_data;
        int unsigned guard;
        drain(SETTLE_CYCLES);
        program_filter(MODE_TOS, $urandom, 16'($urandom));
        src_idle_pct = 38;
        sink_stall_pct <= 38;
        guard = 0;
        while (xfer_phase != PH_DONE && guard < 2000) begin
            h = random_header(is_data);
            send_header(h);
            guard++;
        end
        repeat (20) begin
            h = random_header(is_data);
            send_header(h);
        end
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    // receiver readiness: random stalls, or held off for a long stretch
    always @(posedge aclk)
        m_tready <= !hold_rx && ($urandom_range(0, 99) >= sink_stall_pct);

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // compare each result word with the oldest expectation
    always @(posedge aclk) begin : check_results
        decoded_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_decodes.size() == 0) begin
                $error("result word with nothing expected: section %0d value %0h",
                       m_tuser, m_tdata[31:0]);
                error_count++;
            end else begin
                want = expected_decodes.pop_front();
                check_field("section", 32'(want.section), 32'(m_tuser));
                check_field("value", want.value, m_tdata[31:0]);
                check_field("byte_index", want.byte_index, m_tdata[63:32]);
                check_field("transfer_done", 32'(want.done), 32'(m_tlast));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_filtering();
        test_calibration();
        test_port_extremes();
        test_random_traffic();
        test_backpressure();
        test_completion();
        drain(SETTLE_CYCLES);
        if (error_count == 0 && expected_decodes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
